// ----- rtl/udm_pkg.sv -----
`timescale 1ns / 1ps

package udm_pkg;

    localparam int WordW = 64;

    typedef logic [WordW-1:0] t_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_NORM,
        S_WALK,
        S_HOLD
    } t_state;

    typedef struct packed {
        t_word quotient;
        t_word remainder;
        logic  zero_divisor;
    } t_result;

    typedef struct packed {
        logic  ge;
        logic  eq;
        t_word diff;
    } t_alu_out;

endpackage

// ----- rtl/udm_if.sv -----
`timescale 1ns / 1ps

interface udm_in_if;
    logic           valid;
    logic           ready;
    udm_pkg::t_word dividend;
    udm_pkg::t_word divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink (input valid, input dividend, input divisor, output ready);
endinterface

interface udm_out_if;
    logic           valid;
    logic           ready;
    udm_pkg::t_word quotient;
    udm_pkg::t_word remainder;
    logic           zero_divisor;

    modport source (output valid, output quotient, output remainder, output zero_divisor,
                    input ready);
    modport sink (input valid, input quotient, input remainder, input zero_divisor,
                  output ready);
endinterface

// ----- rtl/udm_alu.sv -----
`timescale 1ns / 1ps

module udm_alu (
    input  udm_pkg::t_word    i_a,
    input  udm_pkg::t_word    i_b,
    output udm_pkg::t_alu_out o_res
);

    logic [udm_pkg::WordW:0] w_sub;

    assign w_sub = {1'b0, i_a} - {1'b0, i_b};

    always_comb begin
        o_res.diff = w_sub[udm_pkg::WordW-1:0];
        o_res.ge   = ~w_sub[udm_pkg::WordW];
        o_res.eq   = (i_a == i_b);
    end

endmodule

// ----- rtl/udm_core.sv -----
`timescale 1ns / 1ps

module udm_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  udm_pkg::t_word   i_dividend,
    input  udm_pkg::t_word   i_divisor,
    input  logic             i_take,
    output logic             o_ready,
    output logic             o_done,
    output udm_pkg::t_result o_result
);

    udm_pkg::t_state   r_state, n_state;
    udm_pkg::t_word    r_num, n_num;
    udm_pkg::t_word    r_den, n_den;
    udm_pkg::t_word    r_bit, n_bit;
    udm_pkg::t_word    r_quo, n_quo;
    logic              r_zero, n_zero;

    udm_pkg::t_word    w_a, w_b;
    udm_pkg::t_word    w_next_den;
    udm_pkg::t_alu_out w_alu;
    logic              w_den_zero;

    assign w_next_den = {r_den[udm_pkg::WordW-2:0], 1'b0};
    assign w_den_zero = (r_den == '0);

    udm_alu u_alu (
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_alu)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            udm_pkg::S_IDLE: begin
                if (i_start) n_state = udm_pkg::S_CHECK;
            end
            udm_pkg::S_CHECK: begin
                if (w_den_zero || !w_alu.ge || w_alu.eq) n_state = udm_pkg::S_HOLD;
                else n_state = udm_pkg::S_NORM;
            end
            udm_pkg::S_NORM: begin
                if (r_den[udm_pkg::WordW-1] || w_alu.ge) n_state = udm_pkg::S_WALK;
            end
            udm_pkg::S_WALK: begin
                if (r_bit[0]) n_state = udm_pkg::S_HOLD;
            end
            udm_pkg::S_HOLD: begin
                if (i_take) n_state = udm_pkg::S_IDLE;
            end
            default: n_state = udm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_num  = r_num;
        n_den  = r_den;
        n_bit  = r_bit;
        n_quo  = r_quo;
        n_zero = r_zero;
        w_a    = r_num;
        w_b    = r_den;
        case (r_state)
            udm_pkg::S_IDLE: begin
                if (i_start) begin
                    n_num  = i_dividend;
                    n_den  = i_divisor;
                    n_bit  = udm_pkg::t_word'(1);
                    n_quo  = '0;
                    n_zero = 1'b0;
                end
            end
            udm_pkg::S_CHECK: begin
                if (w_den_zero) begin
                    n_quo  = '1;
                    n_zero = 1'b1;
                end else if (w_alu.ge && w_alu.eq) begin
                    n_quo = udm_pkg::t_word'(1);
                    n_num = '0;
                end
            end
            udm_pkg::S_NORM: begin
                w_a = w_next_den;
                w_b = r_num;
                if (!r_den[udm_pkg::WordW-1] && !w_alu.ge) begin
                    n_den = w_next_den;
                    n_bit = {r_bit[udm_pkg::WordW-2:0], 1'b0};
                end
            end
            udm_pkg::S_WALK: begin
                if (w_alu.ge) begin
                    n_num = w_alu.diff;
                    n_quo = r_quo | r_bit;
                end
                n_den = {1'b0, r_den[udm_pkg::WordW-1:1]};
                n_bit = {1'b0, r_bit[udm_pkg::WordW-1:1]};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_ready               = (r_state == udm_pkg::S_IDLE);
        o_done                = (r_state == udm_pkg::S_HOLD);
        o_result.quotient     = r_quo;
        o_result.remainder    = r_num;
        o_result.zero_divisor = r_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= udm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_num  <= n_num;
        r_den  <= n_den;
        r_bit  <= n_bit;
        r_quo  <= n_quo;
        r_zero <= n_zero;
    end

endmodule

// ----- rtl/unsigned_divmod_64.sv -----
`timescale 1ns / 1ps
// From input accept to output valid a word passes the check step, the divisor
// normalization steps and the subtract steps, then the output register.
// Zero divisor and dividend not above divisor finish after the check cycle.
// One word is in the divider at a time; a new word is accepted while a result waits,
// so the next word can be accepted once the last result has moved into the output register.
// Reset is synchronous and active low; it clears the sequencer and the output valid.

module unsigned_divmod_64 (
    input  logic      i_clk,
    input  logic      i_rst_n,
    udm_in_if.sink    i_in,
    udm_out_if.source o_out
);

    logic             w_done;
    logic             w_take;
    logic             w_start;
    udm_pkg::t_result w_result;
    logic             r_out_valid;
    udm_pkg::t_result r_out;

    assign w_start = i_in.valid && i_in.ready;
    assign w_take  = w_done && (!r_out_valid || o_out.ready);

    udm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (i_in.dividend),
        .i_divisor  (i_in.divisor),
        .i_take     (w_take),
        .o_ready    (i_in.ready),
        .o_done     (w_done),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.quotient     = r_out.quotient;
    assign o_out.remainder    = r_out.remainder;
    assign o_out.zero_divisor = r_out.zero_divisor;

endmodule

// ----- rtl/udm_checker.sv -----
`timescale 1ns / 1ps

module udm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input udm_pkg::t_word i_quotient,
    input udm_pkg::t_word i_remainder,
    input logic           i_zero_divisor
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Output word dropped before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_quotient) && $stable(i_remainder) && $stable(i_zero_divisor))
        else $error("Output word changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Input accepted while the divider was busy.");

    a_zero_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zero_divisor |-> (i_quotient == '1))
        else $error("Divide by zero did not give an all-ones quotient.");

endmodule

bind unsigned_divmod_64 udm_checker u_udm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_quotient     (o_out.quotient),
    .i_remainder    (o_out.remainder),
    .i_zero_divisor (o_out.zero_divisor)
);

// ----- dv/tb_unsigned_divmod_64.sv -----
`timescale 1ns / 1ps

module tb_unsigned_divmod_64;

    typedef struct packed {
        udm_pkg::t_word dividend;
        udm_pkg::t_word divisor;
    } t_operands;

    localparam int DrainCycles = 140;

    logic i_clk = 1'b0;
    logic i_rst_n;

    udm_in_if  in_if ();
    udm_out_if out_if ();

    unsigned_divmod_64 DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_operands        operand_q[$];
    udm_pkg::t_result pending_results[$];
    udm_pkg::t_result want;

    bit word_pending    = 1'b0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int recv_hold_left  = 0;
    int error_count     = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int zero_div_seen   = 0;
    int zero_quo_seen   = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic udm_pkg::t_result divmod_predict(udm_pkg::t_word dvd,
                                                        udm_pkg::t_word dvs);
        udm_pkg::t_result res;
        udm_pkg::t_word   num;
        udm_pkg::t_word   d;
        udm_pkg::t_word   qbit;
        udm_pkg::t_word   q;
        num  = dvd;
        d    = dvs;
        qbit = 64'd1;
        q    = '0;
        res.zero_divisor = 1'b0;
        if (dvs == '0) begin
            res.quotient     = '1;
            res.remainder    = dvd;
            res.zero_divisor = 1'b1;
        end else if (dvd < dvs) begin
            res.quotient  = '0;
            res.remainder = dvd;
        end else if (dvd == dvs) begin
            res.quotient  = 64'd1;
            res.remainder = '0;
        end else begin
            while (!d[udm_pkg::WordW-1] && ((d << 1) < num)) begin
                d    = d << 1;
                qbit = qbit << 1;
            end
            while (qbit != '0) begin
                if (num >= d) begin
                    num = num - d;
                    q   = q | qbit;
                end
                d    = d >> 1;
                qbit = qbit >> 1;
            end
            res.quotient  = q;
            res.remainder = num;
        end
        return res;
    endfunction

    function automatic udm_pkg::t_word random_width_word();
        int             w;
        udm_pkg::t_word full;
        w    = $urandom_range(0, udm_pkg::WordW);
        full = {$urandom, $urandom};
        if (w == udm_pkg::WordW) begin
            return full;
        end
        return full & ((64'd1 << w) - 64'd1);
    endfunction

    function automatic t_operands random_operands();
        t_operands      ops;
        udm_pkg::t_word a;
        udm_pkg::t_word b;
        a = random_width_word();
        b = random_width_word();
        case ($urandom_range(0, 15))
            0: begin
                ops.dividend = a;
                ops.divisor  = '0;
            end
            1: begin
                ops.dividend = a;
                ops.divisor  = a;
            end
            2: begin
                ops.dividend = (a < b) ? a : b;
                ops.divisor  = (a < b) ? b : a;
            end
            3: begin
                ops.dividend = {$urandom, $urandom};
                ops.divisor  = {$urandom, $urandom};
            end
            4: begin
                ops.dividend = {$urandom, $urandom};
                ops.divisor  = b | {1'b1, 63'd0};
            end
            5: begin
                ops.dividend = '1;
                ops.divisor  = b;
            end
            default: begin
                ops.dividend = a;
                ops.divisor  = b;
            end
        endcase
        return ops;
    endfunction

    task automatic queue_operands(input udm_pkg::t_word dvd, input udm_pkg::t_word dvs);
        t_operands ops;
        ops.dividend = dvd;
        ops.divisor  = dvs;
        operand_q.push_back(ops);
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++) begin
            operand_q.push_back(random_operands());
        end
    endtask

    task automatic wait_drained();
        while (operand_q.size() != 0 || word_pending || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && !word_pending) begin
            if (operand_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_if.valid    <= 1'b1;
                in_if.dividend <= operand_q[0].dividend;
                in_if.divisor  <= operand_q[0].divisor;
                word_pending = 1'b1;
            end else begin
                in_if.valid    <= 1'b0;
                in_if.dividend <= {$urandom, $urandom};
                in_if.divisor  <= {$urandom, $urandom};
            end
        end
    end

    always @(negedge i_clk) begin
        if (recv_hold_left > 0) begin
            recv_hold_left = recv_hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected word, actual q=%h r=%h z=%b", $time,
                         out_if.quotient, out_if.remainder, out_if.zero_divisor);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.zero_divisor) begin
                    zero_div_seen++;
                end
                if (want.quotient == '0) begin
                    zero_quo_seen++;
                end
                if (out_if.quotient !== want.quotient) begin
                    error_count++;
                    $display("%0t: quotient mismatch, expected %h actual %h", $time,
                             want.quotient, out_if.quotient);
                end
                if (out_if.remainder !== want.remainder) begin
                    error_count++;
                    $display("%0t: remainder mismatch, expected %h actual %h", $time,
                             want.remainder, out_if.remainder);
                end
                if (out_if.zero_divisor !== want.zero_divisor) begin
                    error_count++;
                    $display("%0t: zero_divisor mismatch, expected %b actual %b", $time,
                             want.zero_divisor, out_if.zero_divisor);
                end
            end
        end
        if (i_rst_n && in_if.valid && in_if.ready) begin
            pending_results.push_back(divmod_predict(in_if.dividend, in_if.divisor));
            operand_q.delete(0);
            word_pending = 1'b0;
            words_sent++;
        end
    end

    initial begin
        #15_000_000;
        $display("%0t: timeout with %0d words still expected", $time, pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.dividend = '0;
        in_if.divisor  = '0;
        out_if.ready   = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_operands(64'd0, 64'd0);
        queue_operands('1, 64'd0);
        queue_operands(64'd5, 64'd0);
        queue_operands(64'd0, 64'd1);
        queue_operands('1, 64'd1);
        queue_operands('1, '1);
        queue_operands(64'd7, 64'd7);
        queue_operands(64'd3, 64'd10);
        queue_operands(64'hFFFF_FFFF_FFFF_FFFE, '1);
        queue_operands(64'd1, '1);
        queue_operands(64'h8000_0000_0000_0000, 64'd1);
        queue_operands('1, 64'h8000_0000_0000_0000);
        queue_operands(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        queue_operands(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        queue_operands('1, 64'd2);
        queue_operands(64'd100, 64'd7);
        queue_operands('1, 64'hFFFF_FFFF);
        queue_operands(64'h8000_0000_0000_0001, 64'd3);
        queue_operands(64'h1234_5678_9ABC_DEF0, 64'h10);
        queue_operands(64'h8000_0000, 64'h8000_0000);
        queue_operands(64'hFFFF_FFFF_0000_0000, 64'h8000_0000);
        queue_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        wait_drained();

        send_idle_pct = 19;
        recv_idle_pct = 77;
        queue_random(500);
        wait_drained();

        // Hold the output off while words keep arriving so the input side backs up.
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        recv_hold_left = 400;
        queue_random(50);
        wait_drained();

        send_idle_pct = 77;
        recv_idle_pct = 19;
        queue_random(500);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(500);
        wait_drained();

        repeat (DrainCycles) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            error_count++;
            $display("%0t: %0d words never arrived, oldest expected q=%h r=%h z=%b", $time,
                     pending_results.size(), pending_results[0].quotient,
                     pending_results[0].remainder, pending_results[0].zero_divisor);
        end

        $display("Divided %0d operand pairs and checked %0d results, %0d errors.",
                 words_sent, results_checked, error_count);
        $display("Covered %0d divide-by-zero words and %0d zero quotients under stalls.",
                 zero_div_seen, zero_quo_seen);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
